// ===== hw/rtl/vccb_pkg.sv =====
// Shared types and constants of the voxel cluster centroid and box block.
package vccb_pkg;

   localparam int COORD_W  = 14;
   localparam int BOUND_W  = 15;
   localparam int WINLEN_W = 14;
   localparam int MATCH_W  = 11;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 144;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REGION = 2'd1,
      KIND_WINDOW = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOMATCH = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic update;
      logic scan_run;
      logic div_start;
      logic div_run;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic     store_empty;
      logic     scan_last;
      logic     count_zero;
      logic     div_done;
   } sts_type;

endpackage

// ===== hw/rtl/voxel_cluster_centroid_box_core.sv =====
// An add or clear item passes through the update and emit states to its result; a query
// runs the scan, drain, divider-load, divide and emit states over the N stored voxels
// (with no match it skips the divide, on an empty store it goes straight to emit), the
// scan reading through the one store read port and the divider by its one bit a step.
// Throughput is one item at a time; the emit state waits until the result register is free.
// Reset is synchronous, active high, and empties the cluster; no clearing pass.
module voxel_cluster_centroid_box_core #(
   parameter int STORE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // voxel_x, voxel_y, voxel_z, x_low, x_high, y_low, y_high, z_low, z_high,
   // window_length, then zero fill
   input  logic [vccb_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // centroid_x, centroid_y, centroid_z, match_count, box_x_min, box_x_max,
   // box_y_min, box_y_max, box_z_min, box_z_max, then zero fill
   output logic [vccb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                      rsp_tuser
);
   import vccb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   vccb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   vccb_dp #(
      .STORE_DEPTH   (STORE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== hw/rtl/vccb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module vccb_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/vccb_ctrl.sv =====
// Controller state machine that sequences updates, scans, division and results.
module vccb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output vccb_pkg::cmd_type cmd,
   input  vccb_pkg::sts_type sts
);
   import vccb_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UPDATE  = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_DRAIN   = 7'b0001000,
      ST_DIVLOAD = 7'b0010000,
      ST_DIVIDE  = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;
   kind_type  req_kind;

   assign req_kind   = kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_kind == KIND_ADD || req_kind == KIND_CLEAR) begin
                  state_in = ST_UPDATE;
               end else if (sts.store_empty) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIVLOAD;
         end
         ST_DIVLOAD: begin
            if (sts.count_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_run = 1'b1;
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag: set when the output register loads, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_out_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register loaded while a result was still waiting");
   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("controller stayed idle after accepting an item");
   a_scan_nonempty : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !sts.store_empty)
      else $error("scan running over an empty store");
`endif

endmodule

// ===== hw/rtl/vccb_dp.sv =====
// Datapath: voxel store, bounding box, match and accumulate, serial divider.
module vccb_dp #(
   parameter int STORE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_tuser,
   input  logic [vccb_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic [vccb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  vccb_pkg::cmd_type                   cmd,
   output vccb_pkg::sts_type                   sts
);
   import vccb_pkg::*;

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int AW = $clog2(STORE_DEPTH > 1 ? STORE_DEPTH : 2);
   localparam int SW = COORD_W + CW;
   localparam int BW = $clog2(SW);
   localparam int VW = 3 * COORD_W;
   localparam logic signed [BOUND_W-1:0] OFF_BOUND =
      BOUND_W'(-(1 <<< FRACTION_BITS));

   // Request fields.
   logic [COORD_W-1:0]         f_vx, f_vy, f_vz;
   logic signed [BOUND_W-1:0]  f_xl, f_xh, f_yl, f_yh, f_zl, f_zh;
   logic [WINLEN_W-1:0]        f_wl;

   assign f_vx = req_tdata[13:0];
   assign f_vy = req_tdata[27:14];
   assign f_vz = req_tdata[41:28];
   assign f_xl = req_tdata[56:42];
   assign f_xh = req_tdata[71:57];
   assign f_yl = req_tdata[86:72];
   assign f_yh = req_tdata[101:87];
   assign f_zl = req_tdata[116:102];
   assign f_zh = req_tdata[131:117];
   assign f_wl = req_tdata[145:132];

   // Latched item.
   kind_type                  kind_ff;
   logic [VW-1:0]             voxel_ff;
   logic signed [BOUND_W-1:0] xl_ff, xh_ff, yl_ff, yh_ff, zl_ff, zh_ff;
   logic                      ytest_ff, ztest_ff;
   logic [COORD_W-1:0]        win_lo_ff;
   logic [COORD_W:0]          win_hi_ff;

   // Cluster state.
   logic [CW-1:0]      total_ff;
   logic [COORD_W-1:0] lo_ff [3];
   logic [COORD_W-1:0] hi_ff [3];
   logic               box_valid_ff;
   logic               full_ff;

   // Scan and divide.
   logic [CW-1:0]      idx_ff;
   logic               rd_valid_ff;
   logic [SW-1:0]      sum_ff [3];
   logic [CW-1:0]      count_ff;
   logic [1:0]         axis_ff;
   logic [BW-1:0]      bit_ff;
   logic [CW-1:0]      rem_ff;
   logic [SW-1:0]      dvd_ff;
   logic [COORD_W-1:0] cent_ff [3];

   // Output register.
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  store_full;
   logic                  do_write;
   logic [VW-1:0]         rd_data;
   logic [COORD_W-1:0]    rd_c [3];
   logic [COORD_W-1:0]    new_c [3];
   logic                  hit;
   logic [CW:0]           trial;
   logic [CW:0]           cnt_ext;
   logic                  ge;
   logic [CW:0]           diff;
   logic [SW-1:0]         dvd_next;
   logic                  bit_last;
   logic [CW+MATCH_W-1:0] count_wide;

   assign store_full = (total_ff >= CW'(STORE_DEPTH));
   assign do_write   = cmd.update && (kind_ff == KIND_ADD) && !store_full;

   vccb_ram #(
      .WIDTH (VW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data (voxel_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_c[0]  = rd_data[13:0];
   assign rd_c[1]  = rd_data[27:14];
   assign rd_c[2]  = rd_data[41:28];
   assign new_c[0] = voxel_ff[13:0];
   assign new_c[1] = voxel_ff[27:14];
   assign new_c[2] = voxel_ff[41:28];

   // Match test of the voxel just read.
   always_comb begin
      logic signed [BOUND_W:0] sx, sy, sz;
      sx = signed'({2'b00, rd_c[0]});
      sy = signed'({2'b00, rd_c[1]});
      sz = signed'({2'b00, rd_c[2]});
      if (kind_ff == KIND_WINDOW) begin
         hit = ({1'b0, rd_c[0]} >= {1'b0, win_lo_ff}) && ({1'b0, rd_c[0]} <= win_hi_ff);
      end else begin
         hit = (sx >= (BOUND_W+1)'(xl_ff)) && (sx <= (BOUND_W+1)'(xh_ff));
         if (ytest_ff && !((sy >= (BOUND_W+1)'(yl_ff)) && (sy <= (BOUND_W+1)'(yh_ff)))) begin
            hit = 1'b0;
         end
         if (ztest_ff && !((sz >= (BOUND_W+1)'(zl_ff)) && (sz <= (BOUND_W+1)'(zh_ff)))) begin
            hit = 1'b0;
         end
      end
   end

   // One restoring division step.
   assign cnt_ext  = {1'b0, count_ff};
   assign trial    = {rem_ff, dvd_ff[SW-1]};
   assign ge       = (trial >= cnt_ext);
   assign diff     = trial - cnt_ext;
   assign dvd_next = {dvd_ff[SW-2:0], ge};
   assign bit_last = (bit_ff == BW'(SW - 1));

   assign count_wide = {{MATCH_W{1'b0}}, count_ff};

   // Result: status, centroid and match count of a query with matches, and the box after the item.
   always_comb begin
      rsp_data_in   = '0;
      rsp_status_in = STATUS_OK;
      if (kind_ff == KIND_ADD) begin
         rsp_status_in = full_ff ? STATUS_FULL : STATUS_OK;
      end else if (kind_ff == KIND_CLEAR) begin
         rsp_status_in = STATUS_OK;
      end else if (count_ff == '0) begin
         rsp_status_in = STATUS_NOMATCH;
      end else begin
         rsp_status_in      = STATUS_OK;
         rsp_data_in[13:0]  = cent_ff[0];
         rsp_data_in[27:14] = cent_ff[1];
         rsp_data_in[41:28] = cent_ff[2];
         rsp_data_in[52:42] = count_wide[MATCH_W-1:0];
      end
      if (box_valid_ff) begin
         rsp_data_in[66:53]   = lo_ff[0];
         rsp_data_in[80:67]   = hi_ff[0];
         rsp_data_in[94:81]   = lo_ff[1];
         rsp_data_in[108:95]  = hi_ff[1];
         rsp_data_in[122:109] = lo_ff[2];
         rsp_data_in[136:123] = hi_ff[2];
      end
   end

   // Item latch, cluster update, scan, accumulate and divide.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         box_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= '0;
            hi_ff[a] <= '0;
         end
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_run;
         if (cmd.update) begin
            if (kind_ff == KIND_CLEAR) begin
               total_ff     <= '0;
               box_valid_ff <= 1'b0;
               for (int a = 0; a < 3; a++) begin
                  lo_ff[a] <= '0;
                  hi_ff[a] <= '0;
               end
            end else if (!store_full) begin
               total_ff     <= total_ff + CW'(1);
               box_valid_ff <= 1'b1;
               for (int a = 0; a < 3; a++) begin
                  if (!box_valid_ff || new_c[a] < lo_ff[a]) begin
                     lo_ff[a] <= new_c[a];
                  end
                  if (!box_valid_ff || new_c[a] > hi_ff[a]) begin
                     hi_ff[a] <= new_c[a];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= kind_type'(req_tuser);
         voxel_ff  <= {f_vz, f_vy, f_vx};
         xl_ff     <= f_xl;
         xh_ff     <= f_xh;
         yl_ff     <= f_yl;
         yh_ff     <= f_yh;
         zl_ff     <= f_zl;
         zh_ff     <= f_zh;
         ytest_ff  <= (f_yl != OFF_BOUND) && (f_yh != OFF_BOUND);
         ztest_ff  <= (f_zl != OFF_BOUND) && (f_zh != OFF_BOUND);
         win_lo_ff <= box_valid_ff ? lo_ff[0] : '0;
         win_hi_ff <= {1'b0, (box_valid_ff ? lo_ff[0] : COORD_W'(0))} + {1'b0, f_wl};
         idx_ff    <= '0;
         count_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a]  <= '0;
            cent_ff[a] <= '0;
         end
      end
      if (cmd.update) begin
         full_ff <= (kind_ff == KIND_ADD) && store_full;
      end
      if (cmd.scan_run) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (rd_valid_ff && hit) begin
         count_ff <= count_ff + CW'(1);
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= sum_ff[a] + SW'(rd_c[a]);
         end
      end
      if (cmd.div_start) begin
         axis_ff <= 2'd0;
         bit_ff  <= '0;
         rem_ff  <= '0;
         dvd_ff  <= sum_ff[0];
      end
      if (cmd.div_run) begin
         if (bit_last) begin
            cent_ff[axis_ff] <= dvd_next[COORD_W-1:0];
            axis_ff          <= axis_ff + 2'd1;
            bit_ff           <= '0;
            rem_ff           <= '0;
            dvd_ff           <= (axis_ff == 2'd0) ? sum_ff[1] : sum_ff[2];
         end else begin
            bit_ff <= bit_ff + BW'(1);
            rem_ff <= ge ? diff[CW-1:0] : trial[CW-1:0];
            dvd_ff <= dvd_next;
         end
      end
      if (cmd.out_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

   assign sts.store_empty = (total_ff == '0);
   assign sts.scan_last   = (idx_ff == total_ff - CW'(1));
   assign sts.count_zero  = (count_ff == '0);
   assign sts.div_done    = bit_last && (axis_ff == 2'd2);

endmodule
